// File: rtl/tcd_pkg.sv
// Shared types and constants for the tile color dilation unit.
package tcd_pkg;
	localparam int TILE_SIZE = 64;
	localparam int NUM_TILES = 9;
	localparam int TILES_PER_ROW = 3;
	localparam logic [2:0] REQ_LOAD = 3'd0;
	localparam logic [2:0] REQ_SRC = 3'd1;
	localparam logic [2:0] REQ_READ = 3'd2;
	localparam logic [2:0] REQ_COUNT = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;
	localparam logic CFG_GROW = 1'b0;
	localparam logic CFG_SHAPE = 1'b1;
	typedef logic [63:0] pixel_t;
	typedef logic [8:0] tmask_t;
endpackage

// File: rtl/tile_color_dilation_unit.sv
// Tile color dilation unit top level: request sequencer and pixel memory.
// A load passes through the read state only; a count report adds the output state
// and a pixel read adds a read-wait state before it, and the result beat waits on
// out_stall. A source pixel walks its kernel offsets through one read-modify-write
// memory port: each destination pixel takes an address state and a write state,
// with four destination pixels, one per quadrant, per kernel offset. A source with
// zero alpha or a radius below two returns to idle without writing. Clear and the
// pass after reset sweep all 9*TILE_SIZE*TILE_SIZE words one per cycle while no
// request is taken.
module tile_color_dilation_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          req_type,
	input  logic [3:0]          tile_sel,
	input  logic [5:0]          px_x,
	input  logic [5:0]          px_y,
	input  logic [15:0]         in_red,
	input  logic [15:0]         in_green,
	input  logic [15:0]         in_blue,
	input  logic [15:0]         in_alpha,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         out_red,
	output logic [15:0]         out_green,
	output logic [15:0]         out_blue,
	output logic [15:0]         out_alpha,
	output logic [3:0]          tile_count,
	output tcd_pkg::tmask_t     tile_mask,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [5:0]          cfg_data
);
	import tcd_pkg::*;

	localparam int CW = $clog2(TILE_SIZE);
	localparam int DEPTH = NUM_TILES * TILE_SIZE * TILE_SIZE;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = CW + 2;

	localparam logic [2:0] ST_CLR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD = 3'd2;
	localparam logic [2:0] ST_RDW = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;
	localparam logic [2:0] ST_ADDR = 3'd5;
	localparam logic [2:0] ST_RMW = 3'd6;

	logic [2:0] state_q;
	logic [5:0] grow_q;
	logic shape_q;
	tmask_t present_q;
	logic [AW-1:0] clr_q;
	logic [2:0] req_q;
	logic [3:0] sel_q;
	logic [5:0] x_q, y_q;
	pixel_t pix_q;
	logic [CW-1:0] g_q, dx_q, dy_q;
	logic [1:0] quad_q;
	logic [AW-1:0] addr_q;
	logic wr_ok_q;
	pixel_t rd_data_q;
	pixel_t out_pix_q;
	tmask_t out_mask_q;
	logic out_valid_q;

	pixel_t mem [DEPTH];
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	pixel_t mem_wdata;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) || (state_q == ST_CLR);

	// kernel position for the current offset and quadrant
	logic signed [SW-1:0] sx, sy, ox, oy;
	logic [1:0] col, row;
	logic [CW-1:0] lx, ly;
	logic [3:0] tsel;
	logic [CW-1:0] lim;
	logic last_dx, last_dy;
	always_comb begin
		ox = quad_q[0] ? SW'(dx_q) : -SW'(dx_q);
		oy = quad_q[1] ? SW'(dy_q) : -SW'(dy_q);
		sx = SW'(x_q[CW-1:0]) + ox;
		sy = SW'(y_q[CW-1:0]) + oy;
		col = 2'd1;
		row = 2'd1;
		if (sx < 0) col = 2'd0;
		else if (sx >= SW'(TILE_SIZE)) col = 2'd2;
		if (sy < 0) row = 2'd0;
		else if (sy >= SW'(TILE_SIZE)) row = 2'd2;
		lx = sx[CW-1:0];
		ly = sy[CW-1:0];
		tsel = 4'(col) + 4'(TILES_PER_ROW) * 4'(row);
		lim = shape_q ? CW'(g_q - dy_q) : g_q;
		last_dx = (dx_q + CW'(1) >= lim);
		last_dy = (dy_q + CW'(1) >= g_q);
	end

	// the stamp address is read as it is formed, so the data is ready for the write
	logic [AW-1:0] stamp_addr, rd_addr;
	assign stamp_addr = AW'((int'(tsel) * TILE_SIZE + int'(ly)) * TILE_SIZE + int'(lx));
	assign rd_addr = (state_q == ST_ADDR) ? stamp_addr : addr_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_data_q <= mem[rd_addr];
	end

	logic pos_ok, tile_ok;
	assign pos_ok = (int'(x_q) < TILE_SIZE) && (int'(y_q) < TILE_SIZE);
	assign tile_ok = (sel_q < 4'(NUM_TILES));

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = pix_q;
		if (state_q == ST_CLR) begin
			mem_we = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_RMW && wr_ok_q && rd_data_q[63:48] == 16'd0) begin
			mem_we = 1'b1;
		end else if (state_q == ST_RD && req_q == REQ_LOAD && pos_ok && tile_ok) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			grow_q <= '0;
			shape_q <= 1'b0;
			present_q <= '0;
			out_valid_q <= 1'b0;
			dx_q <= '0;
			dy_q <= '0;
			quad_q <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_GROW) grow_q <= cfg_data;
				else shape_q <= cfg_data[0];
			end
			if (state_q == ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						clr_q <= '0;
						state_q <= ST_IDLE;
					end else clr_q <= clr_q + AW'(1);
				end
				ST_IDLE: begin
					if (in_acc) begin
						dx_q <= '0;
						dy_q <= '0;
						quad_q <= 2'd0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					priority case (req_q)
						REQ_LOAD: begin
							if (pos_ok && tile_ok) present_q[sel_q] <= 1'b1;
							state_q <= ST_IDLE;
						end
						REQ_SRC: begin
							if (pos_ok && pix_q[63:48] != 16'd0 && g_q > CW'(1))
								state_q <= ST_ADDR;
							else state_q <= ST_IDLE;
						end
						REQ_READ: state_q <= ST_RDW;
						REQ_COUNT: state_q <= ST_OUT;
						REQ_CLEAR: begin
							present_q <= '0;
							state_q <= ST_CLR;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_RDW: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || !out_stall) state_q <= ST_IDLE;
				end
				ST_ADDR: begin
					if (dx_q != '0 || dy_q != '0) begin
						present_q[tsel] <= 1'b1;
						state_q <= ST_RMW;
					end else begin
						quad_q <= 2'd0;
						dx_q <= CW'(1);
					end
				end
				ST_RMW: begin
					if (quad_q != 2'd3) begin
						quad_q <= quad_q + 2'd1;
						state_q <= ST_ADDR;
					end else begin
						quad_q <= 2'd0;
						if (!last_dx) begin
							dx_q <= dx_q + CW'(1);
							state_q <= ST_ADDR;
						end else if (!last_dy) begin
							dx_q <= '0;
							dy_q <= dy_q + CW'(1);
							state_q <= ST_ADDR;
						end else state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= req_type;
			sel_q <= tile_sel;
			x_q <= px_x;
			y_q <= px_y;
			pix_q <= {in_alpha, in_blue, in_green, in_red};
			g_q <= grow_q[CW-1:0];
			wr_ok_q <= 1'b0;
		end
		if (state_q == ST_IDLE)
			addr_q <= AW'((tile_sel * TILE_SIZE + px_y) * TILE_SIZE + px_x);
		if (state_q == ST_ADDR) begin
			addr_q <= stamp_addr;
			wr_ok_q <= 1'b1;
		end
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			out_pix_q <= (req_q == REQ_READ && pos_ok && tile_ok) ? rd_data_q : '0;
			out_mask_q <= present_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red = out_pix_q[15:0];
	assign out_green = out_pix_q[31:16];
	assign out_blue = out_pix_q[47:32];
	assign out_alpha = out_pix_q[63:48];
	assign tile_mask = out_mask_q;
	assign tile_count = 4'($countones(out_mask_q));

`ifndef ASSERT_OFF
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMW) |-> in_stall) else $error("accepted during rmw");
	a_clr_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !in_acc) else $error("accepted during clear");
	a_rmw_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMW) |-> $past(state_q) == ST_ADDR) else $error("rmw order");
`endif
endmodule

// File: sim/tile_color_dilation_checker.sv
// Checker for the tile color dilation unit: predicts every read and count result and compares.
module tile_color_dilation_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  logic [2:0]      req_type,
	input  logic [3:0]      tile_sel,
	input  logic [5:0]      px_x,
	input  logic [5:0]      px_y,
	input  logic [15:0]     in_red,
	input  logic [15:0]     in_green,
	input  logic [15:0]     in_blue,
	input  logic [15:0]     in_alpha,
	input  logic            out_valid,
	input  logic            out_stall,
	input  logic [15:0]     out_red,
	input  logic [15:0]     out_green,
	input  logic [15:0]     out_blue,
	input  logic [15:0]     out_alpha,
	input  logic [3:0]      tile_count,
	input  tcd_pkg::tmask_t tile_mask,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic            cfg_index,
	input  logic [5:0]      cfg_data,
	output int              errors,
	output int              pending,
	output int              results_seen
);
	import tcd_pkg::*;

	localparam int TSZ = TILE_SIZE;
	localparam int WORDS = NUM_TILES * TSZ * TSZ;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha;
		logic [3:0]  count;
		tmask_t      mask;
	} read_beat_t;

	pixel_t     tile_mem [0:WORDS-1];
	tmask_t     present;
	logic [5:0] grow;
	logic       diamond;
	read_beat_t read_q [$];

	function automatic void wipe_tiles();
		for (int i = 0; i < WORDS; i++)
			tile_mem[i] = '0;
		present = '0;
	endfunction

	function automatic void stamp_px(int x, int y, pixel_t p);
		int col, row, t;
		col = 1;
		row = 1;
		if (x < 0) begin
			col = 0;
			x += TSZ;
		end else if (x >= TSZ) begin
			col = 2;
			x -= TSZ;
		end
		if (y < 0) begin
			row = 0;
			y += TSZ;
		end else if (y >= TSZ) begin
			row = 2;
			y -= TSZ;
		end
		if (x < 0 || x >= TSZ || y < 0 || y >= TSZ)
			return;
		t = col + TILES_PER_ROW * row;
		present[t] = 1'b1;
		if (tile_mem[(t * TSZ + y) * TSZ + x][63:48] == 16'd0)
			tile_mem[(t * TSZ + y) * TSZ + x] = p;
	endfunction

	function automatic void dilate(int x, int y, pixel_t p);
		int g, lim;
		g = int'(grow) % TSZ;
		for (int dy = 0; dy < g; dy++) begin
			lim = diamond ? g - dy : g;
			for (int dx = 0; dx < lim; dx++) begin
				if (dx == 0 && dy == 0)
					continue;
				stamp_px(x - dx, y - dy, p);
				stamp_px(x + dx, y - dy, p);
				stamp_px(x - dx, y + dy, p);
				stamp_px(x + dx, y + dy, p);
			end
		end
	endfunction

	function automatic void predict(logic [2:0] req, logic [3:0] sel, logic [5:0] x,
			logic [5:0] y, pixel_t p);
		read_beat_t e;
		pixel_t rd;
		rd = '0;
		case (req)
			REQ_LOAD: begin
				if (sel < NUM_TILES) begin
					tile_mem[(int'(sel) * TSZ + int'(y)) * TSZ + int'(x)] = p;
					present[sel] = 1'b1;
				end
			end
			REQ_SRC: begin
				if (p[63:48] != 16'd0)
					dilate(int'(x), int'(y), p);
			end
			REQ_CLEAR: wipe_tiles();
			REQ_READ, REQ_COUNT: begin
				if (req == REQ_READ && sel < NUM_TILES)
					rd = tile_mem[(int'(sel) * TSZ + int'(y)) * TSZ + int'(x)];
				e.red = rd[15:0];
				e.green = rd[31:16];
				e.blue = rd[47:32];
				e.alpha = rd[63:48];
				e.count = 4'($countones(present));
				e.mask = present;
				read_q.push_back(e);
			end
			default: ;
		endcase
	endfunction

	assign pending = read_q.size();

	always @(posedge clk or negedge arst_n) begin
		read_beat_t e, got;
		if (!arst_n) begin
			wipe_tiles();
			grow = '0;
			diamond = 1'b0;
			read_q.delete();
			errors = 0;
			results_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{out_red, out_green, out_blue, out_alpha, tile_count, tile_mask};
				results_seen++;
				if (read_q.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, got %p", $time, got);
				end else begin
					e = read_q.pop_front();
					if (got != e) begin
						errors++;
						$display("%0t: mismatch expected %p actual %p", $time, e, got);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_GROW)
					grow = cfg_data;
				else
					diamond = cfg_data[0];
			end
			if (in_valid && !in_stall)
				predict(req_type, tile_sel, px_x, px_y,
					{in_alpha, in_blue, in_green, in_red});
		end
	end
endmodule

// File: sim/tile_color_dilation_unit_test.sv
// Testbench top for the tile color dilation unit: reset, stimulus phases and verdict.
module tile_color_dilation_unit_test;
	import tcd_pkg::*;

	localparam logic [2:0] REQ_RSVD_LO = 3'd5;
	localparam logic [2:0] REQ_RSVD_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic [3:0] tile_sel = '0;
	logic [5:0] px_x = '0;
	logic [5:0] px_y = '0;
	logic [15:0] in_red = '0;
	logic [15:0] in_green = '0;
	logic [15:0] in_blue = '0;
	logic [15:0] in_alpha = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] out_red, out_green, out_blue, out_alpha;
	logic [3:0] tile_count;
	tmask_t tile_mask;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_GROW;
	logic [5:0] cfg_data = '0;

	int errors, pending, results_seen;
	int idle_mode = 0;
	int beats_sent = 0;
	int cur_grow = 0;
	int last_x = 32, last_y = 32;
	int ras_x = 0, ras_y = 0;
	int clears_left = 6;

	tile_color_dilation_unit dut (.*);

	tile_color_dilation_checker chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		case (idle_mode)
			2: out_stall <= $urandom_range(0, 99) < 48;
			3: out_stall <= $urandom_range(0, 99) < 7;
			default: out_stall <= 1'b0;
		endcase
	end

	task automatic send(logic [2:0] req, logic [3:0] sel, logic [5:0] x, logic [5:0] y,
			logic [15:0] r, logic [15:0] g, logic [15:0] b, logic [15:0] a);
		int pct;
		pct = idle_mode == 1 ? 48 : idle_mode == 3 ? 7 : 0;
		while ($urandom_range(0, 99) < pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		tile_sel <= sel;
		px_x <= x;
		px_y <= y;
		in_red <= r;
		in_green <= g;
		in_blue <= b;
		in_alpha <= a;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		beats_sent++;
	endtask

	task automatic write_reg(logic idx, logic [5:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(negedge clk);
			if (cfg_ready)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_GROW)
			cur_grow = int'(val);
	endtask

	// a count beat trails all earlier work, so its arrival means the unit is idle
	task automatic drain();
		send(REQ_COUNT, '0, '0, '0, '0, '0, '0, '0);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic pick_near(output logic [3:0] sel, output logic [5:0] x, output logic [5:0] y);
		int ax, ay, col, row, g;
		g = cur_grow > 12 ? 12 : cur_grow;
		ax = last_x + $urandom_range(0, 2 * g + 2) - (g + 1);
		ay = last_y + $urandom_range(0, 2 * g + 2) - (g + 1);
		col = 1;
		row = 1;
		if (ax < 0) begin
			col = 0;
			ax += 64;
		end else if (ax >= 64) begin
			col = 2;
			ax -= 64;
		end
		if (ay < 0) begin
			row = 0;
			ay += 64;
		end else if (ay >= 64) begin
			row = 2;
			ay -= 64;
		end
		sel = 4'(col + TILES_PER_ROW * row);
		x = 6'(ax);
		y = 6'(ay);
	endtask

	function automatic logic [15:0] rand_chan();
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'd32768;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_beat(bit big);
		int k;
		logic [3:0] sel;
		logic [5:0] x, y;
		logic [15:0] a;
		k = $urandom_range(0, 999);
		a = $urandom_range(0, 9) == 0 ? 16'd0 : rand_chan();
		if (a == 16'd0 && $urandom_range(0, 1))
			a = 16'($urandom_range(1, 65535));
		if (k < 20) begin
			send(3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI)), 4'($urandom), 6'($urandom),
				6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		end else if (k < 23 && clears_left > 0 && !big) begin
			clears_left--;
			send(REQ_CLEAR, 4'($urandom), 6'($urandom), 6'($urandom), '0, '0, '0, '0);
		end else if (k < 220) begin
			pick_near(sel, x, y);
			if ($urandom_range(0, 3) == 0)
				sel = 4'($urandom);
			if ($urandom_range(0, 3) == 0) begin
				x = 6'($urandom);
				y = 6'($urandom);
			end
			send(REQ_LOAD, sel, x, y, rand_chan(), rand_chan(), rand_chan(), a);
		end else if (k < 560 && !big) begin
			if ($urandom_range(0, 4) != 0) begin
				ras_x += $urandom_range(1, 6);
				if (ras_x >= 64) begin
					ras_x = $urandom_range(0, 3);
					ras_y += $urandom_range(1, 4);
					if (ras_y >= 64)
						ras_y = 0;
				end
				last_x = ras_x;
				last_y = ras_y;
			end else begin
				last_x = $urandom_range(0, 63);
				last_y = $urandom_range(0, 63);
			end
			send(REQ_SRC, 4'($urandom), 6'(last_x), 6'(last_y),
				rand_chan(), rand_chan(), rand_chan(), a);
		end else if (k < 920) begin
			pick_near(sel, x, y);
			if ($urandom_range(0, 7) == 0)
				sel = 4'($urandom);
			send(REQ_READ, sel, x, y, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
		end else begin
			send(REQ_COUNT, 4'($urandom), 6'($urandom), 6'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int grows [12] = '{2, 3, 0, 1, 5, 4, 63, 2, 7, 3, 32, 6};
		bit big;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, ignored requests, empty source, tile carry, clear
		write_reg(CFG_GROW, 6'd3);
		write_reg(CFG_SHAPE, 6'd0);
		send(REQ_COUNT, '0, '0, '0, '0, '0, '0, '0);
		send(REQ_LOAD, 4'd0, 6'd0, 6'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
		send(REQ_LOAD, 4'd8, 6'd63, 6'd63, 16'd32768, 16'd32768, 16'd32768, 16'd32768);
		send(REQ_LOAD, 4'd9, 6'd1, 6'd1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
		send(REQ_LOAD, 4'd15, 6'd1, 6'd1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
		send(REQ_READ, 4'd0, 6'd0, 6'd0, '0, '0, '0, '0);
		send(REQ_READ, 4'd8, 6'd63, 6'd63, '0, '0, '0, '0);
		send(REQ_READ, 4'd12, 6'd1, 6'd1, '0, '0, '0, '0);
		send(REQ_SRC, 4'd4, 6'd0, 6'd0, 16'd100, 16'd200, 16'd300, 16'd0);
		send(REQ_SRC, 4'd4, 6'd0, 6'd0, 16'd100, 16'd200, 16'd300, 16'd1);
		send(REQ_SRC, 4'd4, 6'd63, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(REQ_READ, 4'd0, 6'd62, 6'd63, '0, '0, '0, '0);
		send(REQ_READ, 4'd4, 6'd1, 6'd1, '0, '0, '0, '0);
		send(REQ_READ, 4'd8, 6'd0, 6'd1, '0, '0, '0, '0);
		send(REQ_READ, 4'd5, 6'd1, 6'd62, '0, '0, '0, '0);
		send(REQ_RSVD_LO, 4'd4, 6'd5, 6'd5, 16'd1, 16'd1, 16'd1, 16'd1);
		send(REQ_RSVD_HI, 4'd4, 6'd5, 6'd5, 16'd1, 16'd1, 16'd1, 16'd1);
		send(REQ_CLEAR, '0, '0, '0, '0, '0, '0, '0);
		send(REQ_READ, 4'd8, 6'd63, 6'd63, '0, '0, '0, '0);
		drain();
		write_reg(CFG_GROW, 6'd1);
		write_reg(CFG_SHAPE, 6'd1);
		send(REQ_SRC, 4'd4, 6'd10, 6'd10, 16'd5, 16'd6, 16'd7, 16'd8);
		send(REQ_READ, 4'd4, 6'd11, 6'd10, '0, '0, '0, '0);
		drain();

		for (int p = 0; p < 12; p++) begin
			idle_mode = p % 4;
			write_reg(CFG_GROW, 6'(grows[p]));
			write_reg(CFG_SHAPE, 6'(p % 2));
			ras_x = 0;
			ras_y = $urandom_range(0, 8);
			big = grows[p] > 12;
			if (big) begin
				// wide kernels are slow: two sources, then other requests around them, no clears
				for (int s = 0; s < 2; s++) begin
					last_x = $urandom_range(0, 63);
					last_y = $urandom_range(0, 63);
					send(REQ_SRC, 4'd4, 6'(last_x), 6'(last_y), rand_chan(), rand_chan(),
						rand_chan(), 16'($urandom_range(1, 65535)));
				end
				for (int i = 0; i < 20; i++)
					random_beat(1'b1);
			end else begin
				for (int i = 0; i < 175; i++)
					random_beat(1'b0);
			end
			drain();
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d request beats and %0d result beats over 12 kernel settings",
			beats_sent, results_seen);
		$display("radii 0 to 63, square and diamond, with sender and receiver idling");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
